[design/rle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

   localparam int MAX_BLOCK = 63;
   localparam int CNT_W     = 7;
   localparam int ADDR_W    = $clog2(MAX_BLOCK);

   localparam logic [7:0] RUN_FLAG   = 8'h80;
   localparam logic [7:0] SINGLE_HDR = 8'h01;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       burst_last;
   } rsp_type;

   typedef enum logic [2:0] {
      CNT_HOLD,
      CNT_ZERO,
      CNT_ONE,
      CNT_TWO,
      CNT_INC
   } cnt_sel_type;

   typedef enum logic [1:0] {
      LEN_TWO,
      LEN_CM1,
      LEN_C,
      LEN_CP1
   } lit_sel_type;

   typedef enum logic [1:0] {
      RCNT_TWO,
      RCNT_C,
      RCNT_CP1
   } run_sel_type;

   typedef enum logic [1:0] {
      WR_AT0_PREV,
      WR_AT1_IN,
      WR_AT_CNT_X
   } wr_sel_type;

   typedef enum logic [2:0] {
      OSEL_LIT_HDR,
      OSEL_LIT_DATA,
      OSEL_RUN_HDR,
      OSEL_RUN_DATA,
      OSEL_SGL_HDR,
      OSEL_SGL_DATA
   } out_sel_type;

   typedef struct packed {
      logic        accept;
      cnt_sel_type cnt_sel;
      lit_sel_type lit_sel;
      run_sel_type run_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        rd_en;
      logic        idx_clr;
      logic        idx_inc;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic eq;
      logic full;
      logic last_in;
      logic lit_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[design/rle_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module rle_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rle_pkg::req_type      req_data,
   input  wire rle_pkg::dp_cmd_type   cmd,
   input  wire logic                  rsp_stall,
   output rle_pkg::dp_status_type     status,
   output logic                       rsp_valid,
   output rle_pkg::rsp_type           rsp_data
);
   import rle_pkg::*;

   logic [7:0]       prev_ff, prev_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic [7:0]       run_byte_ff, run_byte_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] lit_len_ff, lit_len_in;
   logic [CNT_W-1:0] run_cnt_ff, run_cnt_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [7:0]       mem_ff [MAX_BLOCK];
   logic [7:0]       rd_data_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [7:0]       out_byte;

   always_comb begin
      status.eq       = (req_data.data_byte == prev_ff);
      status.full     = (cnt_ff == CNT_W'(MAX_BLOCK - 1));
      status.last_in  = req_data.stream_end;
      status.lit_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == lit_len_ff);
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   // every accepted byte becomes the new previous byte
   always_comb begin
      prev_in     = cmd.accept ? req_data.data_byte : prev_ff;
      in_byte_in  = cmd.accept ? req_data.data_byte : in_byte_ff;
      run_byte_in = cmd.accept ? prev_ff : run_byte_ff;
   end

   always_comb begin
      case (cmd.cnt_sel)
         CNT_HOLD: cnt_in = cnt_ff;
         CNT_ZERO: cnt_in = '0;
         CNT_ONE:  cnt_in = CNT_W'(1);
         CNT_TWO:  cnt_in = CNT_W'(2);
         CNT_INC:  cnt_in = cnt_ff + CNT_W'(1);
         default:  cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      lit_len_in = lit_len_ff;
      run_cnt_in = run_cnt_ff;
      if (cmd.accept) begin
         case (cmd.lit_sel)
            LEN_TWO: lit_len_in = CNT_W'(2);
            LEN_CM1: lit_len_in = cnt_ff - CNT_W'(1);
            LEN_C:   lit_len_in = cnt_ff;
            LEN_CP1: lit_len_in = cnt_ff + CNT_W'(1);
            default: lit_len_in = cnt_ff;
         endcase
         case (cmd.run_sel)
            RCNT_TWO: run_cnt_in = CNT_W'(2);
            RCNT_C:   run_cnt_in = cnt_ff;
            RCNT_CP1: run_cnt_in = cnt_ff + CNT_W'(1);
            default:  run_cnt_in = cnt_ff;
         endcase
      end
   end

   always_comb begin
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + ADDR_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_AT0_PREV: begin
            wr_addr = '0;
            wr_data = prev_ff;
         end
         WR_AT1_IN: begin
            wr_addr = ADDR_W'(1);
            wr_data = in_byte_ff;
         end
         WR_AT_CNT_X: begin
            wr_addr = cnt_ff[ADDR_W-1:0];
            wr_data = req_data.data_byte;
         end
         default: begin
            wr_addr = '0;
            wr_data = prev_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[idx_ff];
      end
   end

   always_comb begin
      case (cmd.out_sel)
         OSEL_LIT_HDR:  out_byte = {1'b0, lit_len_ff};
         OSEL_LIT_DATA: out_byte = rd_data_ff;
         OSEL_RUN_HDR:  out_byte = RUN_FLAG | {1'b0, run_cnt_ff};
         OSEL_RUN_DATA: out_byte = run_byte_ff;
         OSEL_SGL_HDR:  out_byte = SINGLE_HDR;
         OSEL_SGL_DATA: out_byte = in_byte_ff;
         default:       out_byte = in_byte_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
      if (cmd.out_load) begin
         rsp_in.out_byte   = out_byte;
         rsp_in.burst_last = cmd.out_last;
      end else begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      run_byte_ff <= run_byte_in;
      lit_len_ff  <= lit_len_in;
      run_cnt_ff  <= run_cnt_in;
      idx_ff      <= idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register overwritten while stalled");

   a_lit_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_sel == OSEL_LIT_HDR) |-> (lit_len_ff != '0))
      else $error("empty literal header");

   a_read_in_literal: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (CNT_W'(idx_ff) < lit_len_ff))
      else $error("store read beyond open literal");

endmodule

`default_nettype wire

[design/rle_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rle_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rle_pkg::dp_status_type status,
   output rle_pkg::dp_cmd_type         cmd
);
   import rle_pkg::*;

   typedef enum logic [8:0] {
      ST_READY     = 9'b000000001,
      ST_WR_SECOND = 9'b000000010,
      ST_LIT_HDR   = 9'b000000100,
      ST_LIT_RD    = 9'b000001000,
      ST_LIT_DATA  = 9'b000010000,
      ST_RUN_HDR   = 9'b000100000,
      ST_RUN_DATA  = 9'b001000000,
      ST_SGL_HDR   = 9'b010000000,
      ST_SGL_DATA  = 9'b100000000
   } state_type;

   typedef enum logic [3:0] {
      SEG_IDLE    = 4'b0001,
      SEG_SINGLE  = 4'b0010,
      SEG_RUN     = 4'b0100,
      SEG_LITERAL = 4'b1000
   } seg_type;

   state_type state_ff, state_in;
   seg_type   seg_ff, seg_in;
   logic      lit_pend_ff, lit_pend_in;
   logic      run_pend_ff, run_pend_in;
   logic      sgl_pend_ff, sgl_pend_in;
   logic      two_wr;

   function automatic state_type first_state(input logic lit, input logic run,
                                             input logic sgl);
      state_type s;
      if (lit) begin
         s = ST_LIT_HDR;
      end else if (run) begin
         s = ST_RUN_HDR;
      end else if (sgl) begin
         s = ST_SGL_HDR;
      end else begin
         s = ST_READY;
      end
      return s;
   endfunction

   assign req_stall = (state_ff != ST_READY);

   always_comb begin
      cmd         = '0;
      cmd.cnt_sel = CNT_HOLD;
      cmd.lit_sel = LEN_TWO;
      cmd.run_sel = RCNT_TWO;
      cmd.wr_sel  = WR_AT0_PREV;
      cmd.out_sel = OSEL_LIT_HDR;
      state_in    = state_ff;
      seg_in      = seg_ff;
      lit_pend_in = lit_pend_ff;
      run_pend_in = run_pend_ff;
      sgl_pend_in = sgl_pend_ff;
      two_wr      = 1'b0;

      case (state_ff)
         ST_READY: begin
            if (req_valid) begin
               cmd.accept  = 1'b1;
               lit_pend_in = 1'b0;
               run_pend_in = 1'b0;
               sgl_pend_in = 1'b0;
               case (seg_ff)
                  SEG_IDLE: begin
                     if (status.last_in) begin
                        sgl_pend_in = 1'b1;
                        seg_in      = SEG_IDLE;
                        cmd.cnt_sel = CNT_ZERO;
                     end else begin
                        seg_in      = SEG_SINGLE;
                        cmd.cnt_sel = CNT_ONE;
                     end
                  end
                  SEG_SINGLE: begin
                     if (status.eq) begin
                        if (status.last_in) begin
                           run_pend_in = 1'b1;
                           cmd.run_sel = RCNT_TWO;
                           seg_in      = SEG_IDLE;
                           cmd.cnt_sel = CNT_ZERO;
                        end else begin
                           seg_in      = SEG_RUN;
                           cmd.cnt_sel = CNT_TWO;
                        end
                     end else begin
                        // pending byte goes to entry 0 now, new byte next cycle
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_AT0_PREV;
                        two_wr     = 1'b1;
                        if (status.last_in) begin
                           lit_pend_in = 1'b1;
                           cmd.lit_sel = LEN_TWO;
                           seg_in      = SEG_IDLE;
                           cmd.cnt_sel = CNT_ZERO;
                        end else begin
                           seg_in      = SEG_LITERAL;
                           cmd.cnt_sel = CNT_TWO;
                        end
                     end
                  end
                  SEG_RUN: begin
                     if (status.eq) begin
                        if (status.full || status.last_in) begin
                           run_pend_in = 1'b1;
                           cmd.run_sel = RCNT_CP1;
                           seg_in      = SEG_IDLE;
                           cmd.cnt_sel = CNT_ZERO;
                        end else begin
                           cmd.cnt_sel = CNT_INC;
                        end
                     end else begin
                        run_pend_in = 1'b1;
                        cmd.run_sel = RCNT_C;
                        if (status.last_in) begin
                           sgl_pend_in = 1'b1;
                           seg_in      = SEG_IDLE;
                           cmd.cnt_sel = CNT_ZERO;
                        end else begin
                           seg_in      = SEG_SINGLE;
                           cmd.cnt_sel = CNT_ONE;
                        end
                     end
                  end
                  SEG_LITERAL: begin
                     if (status.eq) begin
                        // last stored byte moves into the new run
                        lit_pend_in = 1'b1;
                        cmd.lit_sel = LEN_CM1;
                        if (status.last_in) begin
                           run_pend_in = 1'b1;
                           cmd.run_sel = RCNT_TWO;
                           seg_in      = SEG_IDLE;
                           cmd.cnt_sel = CNT_ZERO;
                        end else begin
                           seg_in      = SEG_RUN;
                           cmd.cnt_sel = CNT_TWO;
                        end
                     end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_AT_CNT_X;
                        if (status.last_in) begin
                           lit_pend_in = 1'b1;
                           cmd.lit_sel = LEN_CP1;
                           seg_in      = SEG_IDLE;
                           cmd.cnt_sel = CNT_ZERO;
                        end else if (status.full) begin
                           // full literal keeps its newest byte as a pending single
                           lit_pend_in = 1'b1;
                           cmd.lit_sel = LEN_C;
                           seg_in      = SEG_SINGLE;
                           cmd.cnt_sel = CNT_ONE;
                        end else begin
                           cmd.cnt_sel = CNT_INC;
                        end
                     end
                  end
                  default: begin
                     seg_in      = SEG_IDLE;
                     cmd.cnt_sel = CNT_ZERO;
                  end
               endcase
               if (two_wr) begin
                  state_in = ST_WR_SECOND;
               end else begin
                  state_in = first_state(lit_pend_in, run_pend_in, sgl_pend_in);
               end
            end
         end
         ST_WR_SECOND: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_AT1_IN;
            state_in   = first_state(lit_pend_ff, run_pend_ff, sgl_pend_ff);
         end
         ST_LIT_HDR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_LIT_HDR;
               cmd.idx_clr  = 1'b1;
               state_in     = ST_LIT_RD;
            end
         end
         ST_LIT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LIT_DATA;
         end
         ST_LIT_DATA: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_LIT_DATA;
               cmd.out_last = status.lit_last && !run_pend_ff && !sgl_pend_ff;
               if (status.lit_last) begin
                  state_in = first_state(1'b0, run_pend_ff, sgl_pend_ff);
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_LIT_RD;
               end
            end
         end
         ST_RUN_HDR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_RUN_HDR;
               state_in     = ST_RUN_DATA;
            end
         end
         ST_RUN_DATA: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_RUN_DATA;
               cmd.out_last = !sgl_pend_ff;
               state_in     = first_state(1'b0, 1'b0, sgl_pend_ff);
            end
         end
         ST_SGL_HDR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_SGL_HDR;
               state_in     = ST_SGL_DATA;
            end
         end
         ST_SGL_DATA: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_SGL_DATA;
               cmd.out_last = 1'b1;
               state_in     = ST_READY;
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_READY;
         seg_ff      <= SEG_IDLE;
         lit_pend_ff <= 1'b0;
         run_pend_ff <= 1'b0;
         sgl_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         seg_ff      <= seg_in;
         lit_pend_ff <= lit_pend_in;
         run_pend_ff <= run_pend_in;
         sgl_pend_ff <= sgl_pend_in;
      end
   end

   a_no_lit_and_sgl: assert property (@(posedge clock) disable iff (reset)
      !(lit_pend_ff && sgl_pend_ff))
      else $error("literal and single token in one request");

   a_read_before_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIT_DATA) |->
         $past(state_ff == ST_LIT_RD || state_ff == ST_LIT_DATA))
      else $error("literal byte sent without store read");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_last) |=> (state_ff == ST_READY))
      else $error("burst continues after last result");

endmodule

`default_nettype wire

[design/rle_byte_compressor_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream run-length encoder with a 7-bit count. Each request carries one raw
// byte and an end-of-stream flag; results are token bytes (run header 0x80|count
// then the byte, or literal header count then the bytes), with burst_last set on the
// last byte a request produces. A request is taken when the controller is waiting.
// Its results then leave at one byte per cycle for headers and run/single bytes
// while rsp_stall does not hold the output register; each literal byte is first read
// back from a store of MAX_BLOCK entries into a read register before it is loaded
// into the output register. A request that opens a literal from a pending byte passes
// through ST_WR_SECOND for the second store write. A request that yields nothing
// returns the controller to waiting.
module rle_byte_compressor_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rle_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rle_pkg::rsp_type      rsp_data
);
   import rle_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rle_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
